[hw/rtl/rstok_pkg.sv]
// ---------------------------------------------------------------------------
// rstok_pkg
// Shared types, codes and helpers for the resource script tokeniser.
// ---------------------------------------------------------------------------
package rstok_pkg;

    // Token classes as seen on the result stream
    typedef enum logic [3:0] {
        K_EOF      = 4'd0,
        K_EOL      = 4'd1,
        K_COMMA    = 4'd2,
        K_HASH     = 4'd3,
        K_STRING   = 4'd4,
        K_CSTART   = 4'd5,
        K_LCOMMENT = 4'd6,
        K_NUMBER   = 4'd7,
        K_IDENT    = 4'd8,
        K_UNKNOWN  = 4'd9
    } tok_kind_t;

    // Scanner mode between characters
    typedef enum logic [2:0] {
        M_IDLE     = 3'd0,
        M_HASH     = 3'd1,
        M_STRING   = 3'd2,
        M_SLASH    = 3'd3,
        M_LCOMMENT = 3'd4,
        M_MINUS    = 3'd5,
        M_NUMBER   = 3'd6,
        M_IDENT    = 3'd7
    } scan_mode_t;

    // One result beat
    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        tok_kind_t  kind;
        logic       first;
        logic       last;
    } tok_res_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_UNDER);
    endfunction

    function automatic tok_res_t mk_res(input logic [7:0] ch, input logic vld,
                                        input tok_kind_t kind, input logic first,
                                        input logic last);
        tok_res_t r;
        r.ch    = vld ? ch : 8'h00;
        r.vld   = vld;
        r.kind  = kind;
        r.first = first;
        r.last  = last;
        return r;
    endfunction

endpackage

[hw/rtl/resource_script_tokenizer_unit.sv]
// ---------------------------------------------------------------------------
// resource_script_tokenizer_unit
// Character-at-a-time lexer: splits a byte stream into tokens, one token
// character, or none, per output beat with class and start/end marks.
// ---------------------------------------------------------------------------
// Latency: with the queue empty, a character's first result is on m_* the
// cycle after its beat is taken and a second result follows it; results
// already queued ahead of it leave the queue first.
// Throughput: one character per cycle while each gives at most one result
// and m_tready holds; a character that yields two results needs two output
// beats, set by the single-beat output port draining a four-entry result queue.
// Reset: scanner returns to idle between tokens and the queue empties.
// ---------------------------------------------------------------------------
module resource_script_tokenizer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [5:0] m_tuser,   // [0] char_valid, [4:1] token_kind, [5] token_start
    output logic       m_tlast    // token_end
);
    import rstok_pkg::*;

    // Scanner state
    scan_mode_t mode_reg, mode_next;

    // Result queue: registers, one read port at the head
    tok_res_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    // Per-beat decode
    logic [7:0] c;
    logic       eof;
    logic       in_beat, out_beat;

    tok_res_t   idle_res;
    logic       idle_emit;
    scan_mode_t idle_mode;

    tok_res_t   res0, res1;
    logic [1:0] res_cnt;
    tok_kind_t  cont_kind;

    assign c        = s_tdata;
    assign eof      = s_tuser;
    // room for the worst case of two results per character
    assign s_tready = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign out_beat = m_tvalid && m_tready;

    // What a character does when no token is open
    always_comb begin
        idle_emit = 1'b1;
        idle_mode = M_IDLE;
        idle_res  = mk_res(c, 1'b1, K_UNKNOWN, 1'b1, 1'b1);
        if (eof) begin
            idle_res = mk_res(8'h00, 1'b0, K_EOF, 1'b1, 1'b1);
        end else if (c == CH_SPACE || c == CH_TAB) begin
            idle_emit = 1'b0;
        end else if (c == CH_NL) begin
            idle_res = mk_res(c, 1'b1, K_EOL, 1'b1, 1'b1);
        end else if (c == CH_COMMA) begin
            idle_res = mk_res(c, 1'b1, K_COMMA, 1'b1, 1'b1);
        end else if (c == CH_HASH) begin
            idle_res  = mk_res(c, 1'b1, K_HASH, 1'b1, 1'b0);
            idle_mode = M_HASH;
        end else if (c == CH_QUOTE) begin
            idle_res  = mk_res(c, 1'b1, K_STRING, 1'b1, 1'b0);
            idle_mode = M_STRING;
        end else if (c == CH_SLASH) begin
            idle_emit = 1'b0;            // decided by the next character
            idle_mode = M_SLASH;
        end else if (c == CH_MINUS) begin
            idle_emit = 1'b0;            // sign only if a digit follows
            idle_mode = M_MINUS;
        end else if (is_digit(c)) begin
            idle_res  = mk_res(c, 1'b1, K_NUMBER, 1'b1, 1'b0);
            idle_mode = M_NUMBER;
        end else if (is_word_start(c)) begin
            idle_res  = mk_res(c, 1'b1, K_IDENT, 1'b1, 1'b0);
            idle_mode = M_IDENT;
        end
    end

    // Main mode step: up to two results per character
    always_comb begin
        res0      = idle_res;
        res1      = idle_res;
        res_cnt   = {1'b0, idle_emit};
        mode_next = idle_mode;
        cont_kind = K_UNKNOWN;
        case (mode_reg)
            M_HASH, M_LCOMMENT: begin
                cont_kind = (mode_reg == M_HASH) ? K_HASH : K_LCOMMENT;
                if (eof) begin
                    res0    = mk_res(8'h00, 1'b0, cont_kind, 1'b0, 1'b1);
                    res_cnt = 2'd2;
                end else if (c == CH_NL) begin
                    // newline swallowed, closes the token
                    res0      = mk_res(8'h00, 1'b0, cont_kind, 1'b0, 1'b1);
                    res_cnt   = 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    res0      = mk_res(c, 1'b1, cont_kind, 1'b0, 1'b0);
                    res_cnt   = 2'd1;
                    mode_next = mode_reg;
                end
            end
            M_STRING: begin
                if (eof) begin
                    res0    = mk_res(8'h00, 1'b0, K_STRING, 1'b0, 1'b1);
                    res_cnt = 2'd2;
                end else if (c == CH_QUOTE) begin
                    res0      = mk_res(c, 1'b1, K_STRING, 1'b0, 1'b1);
                    res_cnt   = 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    res0      = mk_res(c, 1'b1, K_STRING, 1'b0, 1'b0);
                    res_cnt   = 2'd1;
                    mode_next = M_STRING;
                end
            end
            M_SLASH: begin
                if (!eof && c == CH_STAR) begin
                    res0      = mk_res(CH_SLASH, 1'b1, K_CSTART, 1'b1, 1'b0);
                    res1      = mk_res(CH_STAR, 1'b1, K_CSTART, 1'b0, 1'b1);
                    res_cnt   = 2'd2;
                    mode_next = M_IDLE;
                end else if (!eof && c == CH_SLASH) begin
                    res0      = mk_res(CH_SLASH, 1'b1, K_LCOMMENT, 1'b1, 1'b0);
                    res1      = mk_res(CH_SLASH, 1'b1, K_LCOMMENT, 1'b0, 1'b0);
                    res_cnt   = 2'd2;
                    mode_next = M_LCOMMENT;
                end else begin
                    // lone '/', then the character again from idle
                    res0    = mk_res(CH_SLASH, 1'b1, K_UNKNOWN, 1'b1, 1'b1);
                    res_cnt = 2'd1 + {1'b0, idle_emit};
                end
            end
            M_MINUS: begin
                if (!eof && is_digit(c)) begin
                    res0      = mk_res(CH_MINUS, 1'b1, K_NUMBER, 1'b1, 1'b0);
                    res1      = mk_res(c, 1'b1, K_NUMBER, 1'b0, 1'b0);
                    res_cnt   = 2'd2;
                    mode_next = M_NUMBER;
                end else begin
                    res0    = mk_res(CH_MINUS, 1'b1, K_UNKNOWN, 1'b1, 1'b1);
                    res_cnt = 2'd1 + {1'b0, idle_emit};
                end
            end
            M_NUMBER, M_IDENT: begin
                cont_kind = (mode_reg == M_NUMBER) ? K_NUMBER : K_IDENT;
                if (!eof && (is_word_start(c) || is_digit(c))) begin
                    res0      = mk_res(c, 1'b1, cont_kind, 1'b0, 1'b0);
                    res_cnt   = 2'd1;
                    mode_next = mode_reg;
                end else begin
                    // lookahead close, character re-handled from idle
                    res0    = mk_res(8'h00, 1'b0, cont_kind, 1'b0, 1'b1);
                    res_cnt = 2'd1 + {1'b0, idle_emit};
                end
            end
            default: begin
                res0    = idle_res;
                res_cnt = {1'b0, idle_emit};
            end
        endcase
    end

    // Queue pointers and fill
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_beat) begin
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(res_cnt);
            count_next  = count_next + (FIFO_AW+1)'(res_cnt);
        end
        if (out_beat) begin
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
            count_next  = count_next - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (in_beat) begin
                mode_reg <= mode_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge aclk) begin
        if (in_beat && res_cnt != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (in_beat && res_cnt == 2'd2) begin
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    // Head of queue onto the master side
    assign m_tdata = fifo_reg[rd_ptr_reg].ch;
    assign m_tuser = {fifo_reg[rd_ptr_reg].first, fifo_reg[rd_ptr_reg].kind,
                      fifo_reg[rd_ptr_reg].vld};
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

endmodule
